FILE: src/nwa_pkg.sv
// Shared constants, types and helper functions of the NFA word acceptor.
`default_nettype none

package nwa_pkg;

    // Automaton size.
    localparam int NUM_STATES  = 16;
    localparam int NUM_SYMBOLS = 256;

    // Derived widths.
    localparam int SYM_AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    // Request opcodes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_START = 1'b0;
    localparam logic CFG_FINAL = 1'b1;

    typedef logic [NUM_STATES-1:0] state_set_t;
    typedef logic [SYM_AW-1:0]     sym_addr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      clr_we;     // clearing pass writes one row of zeros
        sym_addr_t clr_addr;   // row being cleared
        logic      wr_en;      // table write request accepted
        logic      rd_en;      // word byte accepted, read all banks
        logic      init_load;  // load the initial set into the active set
        logic      step;       // replace the active set with the next set
        logic      out_load;   // capture the accept decision
    } dp_cmd_t;

    // One-hot set holding only the start state, empty when out of range.
    function automatic state_set_t initial_set(input logic [3:0] start);
        state_set_t set;
        set = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            set[i] = (32'(start) == i);
        end
        return set;
    endfunction

    // True when the byte has an entry in the table.
    function automatic logic symbol_ok(input logic [7:0] sym);
        return (32'(sym) < NUM_SYMBOLS);
    endfunction

endpackage

`default_nettype wire

FILE: src/nfa_word_acceptor.sv
// A last byte goes from the registered bank read through the step state to the result state; an
// empty word goes straight there. One table write per cycle while idle; a word byte holds the
// input while its bank read is stepped into the active set, a last byte or an empty word also
// while the result is loaded. A result waits in an output register; while it is stalled the next
// result waits in the block and in_stall stays high. After reset a clearing pass zeroes the
// table with in_stall high. Configuration writes are taken in every cycle, also during clearing.
`default_nettype none

module nfa_word_acceptor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  symbol,
    input  wire logic        is_last,
    input  wire logic [3:0]  source_state,
    input  wire logic [15:0] next_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    import nwa_pkg::*;

    dp_cmd_t cmd;

    // Configuration registers are always writable.
    assign cfg_ready = 1'b1;

    // Control.
    nwa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath.
    nwa_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .symbol       (symbol),
        .source_state (source_state),
        .next_mask    (next_mask),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accepted     (accepted)
    );

endmodule

`default_nettype wire

FILE: src/nwa_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module nwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/nwa_ctrl.sv
// Controller state machine: clearing pass, request sequencing and output handshake.
`default_nettype none

module nwa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       opcode,
    input  wire logic             is_last,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output nwa_pkg::dp_cmd_t      cmd
);

    import nwa_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_STEP   = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    sym_addr_t clr_cnt_reg, clr_cnt_next;
    logic      in_word_reg, in_word_next;
    logic      last_reg, last_next;
    logic      out_valid_reg, out_valid_next;

    logic accept;
    logic out_free;
    logic clr_done;

    // Handshake decode.
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign clr_done = (clr_cnt_reg == sym_addr_t'(NUM_SYMBOLS - 1));

    // Next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        in_word_next   = in_word_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.clr_addr   = clr_cnt_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_we   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_WRITE:
                        begin
                            cmd.wr_en = 1'b1;
                        end
                        OP_BYTE:
                        begin
                            cmd.rd_en     = 1'b1;
                            cmd.init_load = !in_word_reg;
                            in_word_next  = 1'b1;
                            last_next     = is_last;
                            state_next    = ST_STEP;
                        end
                        OP_EMPTY:
                        begin
                            cmd.init_load = 1'b1;
                            in_word_next  = 1'b0;
                            state_next    = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (last_reg)
                begin
                    in_word_next = 1'b0;
                    state_next   = ST_RESULT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            in_word_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            in_word_reg   <= in_word_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/nwa_dpath.sv
// Datapath: per-state table banks, active set, configuration and result register.
`default_nettype none

module nwa_dpath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nwa_pkg::dp_cmd_t cmd,
    input  wire logic [7:0]       symbol,
    input  wire logic [3:0]       source_state,
    input  wire logic [15:0]      next_mask,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [15:0]      cfg_data,
    output logic                  accepted
);

    import nwa_pkg::*;

    logic [3:0]  start_reg;
    logic [15:0] final_reg;
    state_set_t  active_reg, active_next;
    logic        sym_ok_reg;
    logic        accepted_reg;

    state_set_t  row [NUM_STATES];
    state_set_t  wr_row;
    sym_addr_t   waddr;
    logic [63:0] mask_ext;
    logic [63:0] final_ext;
    state_set_t  final_set;
    logic        in_sym_ok;

    // Table write data keeps only bits of existing states.
    assign mask_ext  = {48'b0, next_mask};
    assign final_ext = {48'b0, final_reg};
    assign final_set = final_ext[NUM_STATES-1:0];
    assign in_sym_ok = symbol_ok(symbol);
    assign wr_row    = cmd.clr_we ? '0 : mask_ext[NUM_STATES-1:0];
    assign waddr     = cmd.clr_we ? cmd.clr_addr : symbol[SYM_AW-1:0];

    // One table bank per source state, all read at the same byte.
    for (genvar b = 0; b < NUM_STATES; b++)
    begin : g_bank
        logic bank_we;

        assign bank_we = cmd.clr_we ||
                         (cmd.wr_en && in_sym_ok && (32'(source_state) == b));

        nwa_ram #(
            .WIDTH (NUM_STATES),
            .DEPTH (NUM_SYMBOLS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we),
            .waddr (waddr),
            .wdata (wr_row),
            .re    (cmd.rd_en),
            .raddr (symbol[SYM_AW-1:0]),
            .rdata (row[b])
        );
    end

    // OR of the rows of all active states.
    always_comb
    begin
        active_next = '0;
        for (int b = 0; b < NUM_STATES; b++)
        begin
            if (active_reg[b])
            begin
                active_next = active_next | row[b];
            end
        end
        if (!sym_ok_reg)
        begin
            active_next = '0;
        end
    end

    // Active set and byte range flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            sym_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_load)
            begin
                active_reg <= initial_set(start_reg);
            end
            else if (cmd.step)
            begin
                active_reg <= active_next;
            end
            if (cmd.rd_en)
            begin
                sym_ok_reg <= in_sym_ok;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            final_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START: start_reg <= cfg_data[3:0];
                CFG_FINAL: final_reg <= cfg_data;
                default:   start_reg <= start_reg;
            endcase
        end
    end

    // Accept decision of the finished word.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            accepted_reg <= |(active_reg & final_set);
        end
    end

    assign accepted = accepted_reg;

endmodule

`default_nettype wire

FILE: test/nwa_accept_checker.sv
// Checker that predicts and compares the accept verdicts of the NFA word acceptor.
`timescale 1ns / 1ps

module nwa_accept_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  symbol,
    input  wire logic        is_last,
    input  wire logic [3:0]  source_state,
    input  wire logic [15:0] next_mask,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic        accepted,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               mismatch_count,
    output int               verdicts_owed
);
    import nwa_pkg::*;

    // Shadow copy of the automaton: transition rows, active set and registers.
    state_set_t trans_rows [NUM_STATES][NUM_SYMBOLS];
    state_set_t live_set;
    logic       mid_word;
    logic [3:0] start_idx;
    state_set_t accept_mask;

    // Verdicts owed by the block, oldest first.
    logic       expected_verdicts [$];
    logic       oldest_verdict;

    // Set holding the start state alone, or nothing when it is out of range.
    function automatic state_set_t seed_set(input logic [3:0] idx);
        state_set_t s;
        s = '0;
        if (int'(idx) < NUM_STATES)
        begin
            s[idx] = 1'b1;
        end
        return s;
    endfunction

    // Union of the rows of every active state for one byte.
    function automatic state_set_t next_active(input state_set_t cur, input logic [7:0] sym);
        state_set_t acc;
        acc = '0;
        if (int'(sym) < NUM_SYMBOLS)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                if (cur[s])
                begin
                    acc |= trans_rows[s][sym];
                end
            end
        end
        return acc;
    endfunction

    task automatic note_miss(input string what, input logic exp_bit, input logic got_bit);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t ns: %s: expected accepted=%b, got %b",
                     $time, what, exp_bit, got_bit);
        end
    endtask

    // Watch all three channels at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STATES; s++)
            begin
                for (int c = 0; c < NUM_SYMBOLS; c++)
                begin
                    trans_rows[s][c] = '0;
                end
            end
            live_set       = '0;
            mid_word       = 1'b0;
            start_idx      = '0;
            accept_mask    = '0;
            expected_verdicts.delete();
            mismatch_count = 0;
            verdicts_owed  = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START)
                begin
                    start_idx = cfg_data[3:0];
                end
                else
                begin
                    accept_mask = state_set_t'(cfg_data);
                end
            end

            // Compare a delivered verdict with the oldest one owed.
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    note_miss("verdict with none owed", 1'bx, accepted);
                end
                else
                begin
                    oldest_verdict = expected_verdicts.pop_front();
                    if (accepted !== oldest_verdict)
                    begin
                        note_miss("verdict differs", oldest_verdict, accepted);
                    end
                end
            end

            // Advance the shadow automaton on each accepted request.
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_WRITE:
                    begin
                        if (int'(source_state) < NUM_STATES && int'(symbol) < NUM_SYMBOLS)
                        begin
                            trans_rows[source_state][symbol] = state_set_t'(next_mask);
                        end
                    end
                    OP_BYTE:
                    begin
                        if (!mid_word)
                        begin
                            live_set = seed_set(start_idx);
                            mid_word = 1'b1;
                        end
                        live_set = next_active(live_set, symbol);
                        if (is_last)
                        begin
                            expected_verdicts.push_back(|(live_set & accept_mask));
                            mid_word = 1'b0;
                        end
                    end
                    OP_EMPTY:
                    begin
                        live_set = seed_set(start_idx);
                        mid_word = 1'b0;
                        expected_verdicts.push_back(|(live_set & accept_mask));
                    end
                    default:
                    begin
                    end
                endcase
            end

            verdicts_owed = expected_verdicts.size();
        end
    end

endmodule

FILE: test/tb.sv
// Top of the NFA word acceptor testbench: clock, reset, request traffic and the verdict.
`timescale 1ns / 1ps

module tb;
    import nwa_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         NUM_SEGS    = 6;
    localparam int         SEG_ITEMS   = 190;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [7:0]  symbol;
    logic        is_last;
    logic [3:0]  source_state;
    logic [15:0] next_mask;
    logic        out_valid;
    logic        out_stall;
    logic        accepted;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int          mismatch_count;
    int          verdicts_owed;
    int          send_idle;
    int          recv_idle;
    int          seg_items;
    int unsigned cycles;
    logic [7:0]  alpha [4];

    nfa_word_acceptor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .symbol       (symbol),
        .is_last      (is_last),
        .source_state (source_state),
        .next_mask    (next_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    nwa_accept_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .symbol         (symbol),
        .is_last        (is_last),
        .source_state   (source_state),
        .next_mask      (next_mask),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accepted       (accepted),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .verdicts_owed  (verdicts_owed)
    );

    // 4 ns clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Present one request at a falling edge and hold it until it is taken.
    task automatic send_req(input logic [1:0] op, input logic [7:0] sym, input logic last,
                            input logic [3:0] src, input logic [15:0] mask);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        symbol       <= sym;
        is_last      <= last;
        source_state <= src;
        next_mask    <= mask;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_write(input logic [3:0] src, input logic [7:0] sym,
                              input logic [15:0] mask);
        send_req(OP_WRITE, sym, 1'($urandom), src, mask);
        seg_items++;
    endtask

    task automatic send_byte(input logic [7:0] sym, input logic last);
        send_req(OP_BYTE, sym, last, 4'($urandom), 16'($urandom));
        seg_items++;
    endtask

    task automatic send_empty();
        send_req(OP_EMPTY, 8'($urandom), 1'($urandom), 4'($urandom), 16'($urandom));
        seg_items++;
    endtask

    // Mostly bytes of the segment's small alphabet, so words stay alive.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(99) < 85)
        begin
            return alpha[$urandom_range(3)];
        end
        return 8'($urandom);
    endfunction

    // One or two next states, which keeps active sets from exploding.
    function automatic logic [15:0] sparse_mask();
        logic [15:0] m;
        m = 16'h0001 << $urandom_range(15);
        if ($urandom_range(1) == 1)
        begin
            m |= 16'h0001 << $urandom_range(15);
        end
        return m;
    endfunction

    task automatic send_word(input int len, input bit close);
        for (int i = 0; i < len; i++)
        begin
            send_byte(pick_byte(), close && (i == len - 1));
        end
    endtask

    // Stop sending until every owed verdict has come, then let the pipe empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (verdicts_owed != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int pick;
        int wmask;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_WRITE;
        symbol       = '0;
        is_last      = 1'b0;
        source_state = '0;
        next_mask    = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_START;
        cfg_data     = '0;
        cycles       = 0;
        send_idle    = 16;
        recv_idle    = 53;
        seg_items    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests: start state alone accepting.
        write_reg(CFG_START, 16'h0000);
        write_reg(CFG_FINAL, 16'h0001);
        send_empty();
        // The cleared table kills any word.
        send_byte(8'h00, 1'b1);
        send_write(4'd0, 8'h00, 16'h0002);
        send_write(4'd1, 8'hFF, 16'hFFFF);
        send_write(4'd15, 8'h41, 16'h8001);
        send_write(4'd0, 8'hFF, 16'h8000);
        // Fan out to every state, then a single non-final state.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        // A table write in the middle of a word keeps the word going.
        send_byte(8'h00, 1'b0);
        send_write(4'd1, 8'h10, 16'h0001);
        send_byte(8'h10, 1'b1);
        // An empty word abandons the partial word.
        send_byte(8'h00, 1'b0);
        send_empty();
        send_byte(8'h00, 1'b1);
        send_req(OP_UNUSED, 8'hFF, 1'b1, 4'hF, 16'hFFFF);
        // Once the set is empty it stays empty.
        send_byte(8'h77, 1'b0);
        send_byte(8'h00, 1'b1);
        // Last state as start, with upper data bits set on the write.
        settle();
        write_reg(CFG_START, 16'hFFFF);
        write_reg(CFG_FINAL, 16'h8000);
        send_empty();
        send_byte(8'h41, 1'b1);
        settle();
        write_reg(CFG_FINAL, 16'h0000);
        send_empty();
        send_byte(8'h41, 1'b1);
        settle();
        write_reg(CFG_FINAL, 16'hFFFF);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b1);

        // Random segments, each with its own registers and alphabet.
        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    send_idle = 16;
                    recv_idle = 53;
                end
                1:
                begin
                    send_idle = 53;
                    recv_idle = 16;
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            settle();
            if (seg == 0)
            begin
                write_reg(CFG_START, 16'h0000);
                write_reg(CFG_FINAL, 16'hFFFF);
            end
            else
            begin
                write_reg(CFG_START, 16'($urandom));
                write_reg(CFG_FINAL, 16'($urandom));
            end
            for (int a = 0; a < 4; a++)
            begin
                alpha[a] = 8'($urandom);
            end

            // Populate the alphabet's rows so that words get past the first byte.
            for (int s = 0; s < NUM_STATES; s++)
            begin
                for (int a = 0; a < 4; a++)
                begin
                    send_write(4'(s), alpha[a], sparse_mask());
                end
            end

            seg_items = 0;
            while (seg_items < SEG_ITEMS)
            begin
                if ($urandom_range(199) == 0)
                begin
                    settle();
                end
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    wmask = $urandom_range(9);
                    send_write(4'($urandom),
                               ($urandom_range(1) == 1) ? alpha[$urandom_range(3)]
                                                        : 8'($urandom),
                               (wmask < 6) ? sparse_mask() :
                               (wmask < 8) ? 16'($urandom) :
                               (wmask < 9) ? 16'h0000 : 16'hFFFF);
                end
                else if (pick < 20)
                begin
                    send_empty();
                end
                else if (pick < 24)
                begin
                    send_req(OP_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom),
                             16'($urandom));
                end
                else if (pick < 28)
                begin
                    // Unterminated fragment; whatever follows continues it.
                    send_word($urandom_range(1, 3), 1'b0);
                end
                else
                begin
                    send_word(($urandom_range(3) == 0) ? $urandom_range(1, 12)
                                                       : $urandom_range(1, 5), 1'b1);
                end
            end
            // Close any word left open before the registers change.
            send_empty();
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/nwa_pkg.sv
src/nwa_ram.sv
src/nwa_ctrl.sv
src/nwa_dpath.sv
src/nfa_word_acceptor.sv
test/nwa_accept_checker.sv
test/tb.sv
